@@ rtl/pst_pkg.sv @@
package pst_pkg;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_FRAMES      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POSITION_STEP    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ORIENTATION_STEP = 8'd2;

    localparam logic [2:0] STATUS_INVALID      = 3'd0;
    localparam logic [2:0] STATUS_STARTED      = 3'd1;
    localparam logic [2:0] STATUS_DUPLICATE    = 3'd2;
    localparam logic [2:0] STATUS_RESET        = 3'd3;
    localparam logic [2:0] STATUS_ACCUMULATING = 3'd4;
    localparam logic [2:0] STATUS_READY        = 3'd5;

    localparam int SQRT_STEPS   = 32;
    localparam int DIV_QBITS    = 16;
    localparam int CORDIC_STEPS = 21;
    localparam logic [14:0] ANGLE_LIMIT = 15'd25736;
    localparam logic [15:0] Q_ONE_Q14   = 16'd16384;

    typedef enum logic [4:0] {
        S_IDLE,
        S_QSQ_MUL,
        S_QSQ_ACC,
        S_CHECK,
        S_LEN,
        S_DIV_GO,
        S_NORM,
        S_DECIDE,
        S_PSQ_MUL,
        S_PSQ_ACC,
        S_PSQ_CHK,
        S_PSQRT,
        S_DOT_MUL,
        S_DOT_ACC,
        S_DSQ_MUL,
        S_DSQ_SUB,
        S_ACOS_SQRT,
        S_CORDIC,
        S_FINISH,
        S_OUT
    } state_t;

    // atan(2^-i) in units of 2^-20 rad
    function automatic logic [19:0] atan_val(input logic [4:0] i);
        logic [19:0] v;
        case (i)
            5'd0:  v = 20'd823550;
            5'd1:  v = 20'd486170;
            5'd2:  v = 20'd256879;
            5'd3:  v = 20'd130396;
            5'd4:  v = 20'd65451;
            5'd5:  v = 20'd32757;
            5'd6:  v = 20'd16383;
            5'd7:  v = 20'd8192;
            5'd8:  v = 20'd4096;
            5'd9:  v = 20'd2048;
            5'd10: v = 20'd1024;
            5'd11: v = 20'd512;
            5'd12: v = 20'd256;
            5'd13: v = 20'd128;
            5'd14: v = 20'd64;
            5'd15: v = 20'd32;
            5'd16: v = 20'd16;
            5'd17: v = 20'd8;
            5'd18: v = 20'd4;
            5'd19: v = 20'd2;
            5'd20: v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

endpackage

@@ rtl/pst_sqrt.sv @@
module pst_sqrt
    import pst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [35:0] cur;
    logic [35:0] trial;

    assign cur   = {rem_reg, rad_reg[63:62]};
    assign trial = {2'b00, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 5'(SQRT_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // two radicand bits per cycle, one root bit
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            rad_reg <= {rad_reg[61:0], 2'b00};
            cnt_reg <= cnt_reg + 5'd1;
            if (cur >= trial) begin
                rem_reg  <= 34'(cur - trial);
                root_reg <= {root_reg[30:0], 1'b1};
            end else begin
                rem_reg  <= cur[33:0];
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/pst_div.sv @@
module pst_div
    import pst_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [43:0]          num,
    input  logic [30:0]          den,
    output logic                 done,
    output logic [DIV_QBITS-1:0] quot
);

    logic [43:0]          rem_reg;
    logic [45:0]          dsh_reg;
    logic [DIV_QBITS-1:0] quot_reg;
    logic [3:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 fits;

    assign fits = {2'b00, rem_reg} >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 4'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // one quotient bit per cycle, divisor slides down
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num;
            dsh_reg  <= {den, 15'd0};
            quot_reg <= '0;
            cnt_reg  <= 4'(DIV_QBITS - 1);
        end else if (busy_reg) begin
            dsh_reg <= {1'b0, dsh_reg[45:1]};
            cnt_reg <= cnt_reg - 4'd1;
            quot_reg <= {quot_reg[DIV_QBITS-2:0], fits};
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg[43:0];
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ rtl/pst_cordic.sv @@
module pst_cordic
    import pst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [28:0] x0,
    input  logic [28:0] y0,
    output logic        done,
    output logic [14:0] step
);

    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic signed [23:0] z_reg;
    logic [4:0]         i_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic signed [23:0] a;
    logic [23:0]        zc;
    logic [17:0]        r;

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign a  = signed'({4'd0, atan_val(i_reg)});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && i_reg == 5'(CORDIC_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // vectoring: drive y toward zero, collect the angle in z
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= signed'({3'd0, x0});
            y_reg <= signed'({3'd0, y0});
            z_reg <= '0;
            i_reg <= '0;
        end else if (busy_reg) begin
            i_reg <= i_reg + 5'd1;
            if (!y_reg[31]) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + a;
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - a;
            end
        end
    end

    assign zc   = z_reg[23] ? 24'd0 : z_reg;
    assign r    = 18'((zc + 24'd32) >> 6);
    assign step = (r > {3'd0, ANGLE_LIMIT}) ? ANGLE_LIMIT : r[14:0];
    assign done = done_reg;

endmodule

@@ rtl/pose_stability_tracker.sv @@
// Pose stability tracker. One pose sample (frame number, Q2.14 quaternion,
// Q16.16 position) goes in per transfer and one result (status, position step,
// orientation step) comes out. The block takes one sample at a time: s_ready is
// high only while no sample is in work. A compared sample makes up to three
// passes through the shared square root unit, four divisions for quaternion
// normalization and 21 CORDIC iterations, with all products taken from one
// 32x32 multiplier. A finished result sits in the output register while the
// next sample is taken. Configuration writes are always accepted; unknown
// indexes are dropped.
module pose_stability_tracker
    import pst_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [63:0]          s_frame_number,
    input  logic signed [15:0]   s_quat_x,
    input  logic signed [15:0]   s_quat_y,
    input  logic signed [15:0]   s_quat_z,
    input  logic signed [15:0]   s_quat_w,
    input  logic signed [31:0]   s_pos_x,
    input  logic signed [31:0]   s_pos_y,
    input  logic signed [31:0]   s_pos_z,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [31:0]          m_position_step,
    output logic [14:0]          m_orientation_step
);

    state_t state_reg, state_next;

    logic [15:0] req_frames_reg;
    logic [30:0] max_pos_reg;
    logic [14:0] max_ori_reg;

    logic               have_reg;
    logic [63:0]        last_frame_reg;
    logic signed [15:0] last_ori_reg [0:3];
    logic signed [31:0] last_pos_reg [0:2];
    logic [15:0]        count_reg;

    logic [63:0]        frame_reg;
    logic signed [15:0] q_reg [0:3];
    logic signed [31:0] p_reg [0:2];
    logic signed [15:0] n_reg [0:3];
    logic [1:0]         idx_reg;
    logic [65:0]        acc_reg;
    logic signed [31:0] dot_reg;
    logic [30:0]        len_reg;
    logic [63:0]        prod_reg;
    logic [31:0]        pstep_reg;
    logic [28:0]        dmag_reg;

    logic [2:0]  res_status_reg;
    logic [31:0] res_pos_reg;
    logic [14:0] res_ori_reg;

    logic        m_valid_reg;
    logic [2:0]  m_status_reg;
    logic [31:0] m_pos_reg;
    logic [14:0] m_ori_reg;

    logic        s_fire;
    logic        out_load;
    logic        invalid;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] qmag;
    logic [31:0] pmag;
    logic [31:0] dot_abs;
    logic [28:0] dmag;
    logic [16:0] nmag;
    logic [15:0] ncap;
    logic        fin_rst;
    logic [15:0] cnt_up;

    logic        sqrt_start;
    logic [63:0] sqrt_in;
    logic        sqrt_done;
    logic [31:0] sqrt_root;
    logic        div_start;
    logic        div_done;
    logic [DIV_QBITS-1:0] div_quot;
    logic        cordic_start;
    logic        cordic_done;
    logic [14:0] cordic_step;

    assign s_fire    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    assign invalid = (frame_reg == 64'd0) || (acc_reg < 66'd3) ||
                     (req_frames_reg == 16'd0) || (max_pos_reg == 31'd0) ||
                     (max_ori_reg == 15'd0);

    assign qmag = mag33(33'(q_reg[idx_reg]));
    assign pmag = mag33(33'(p_reg[idx_reg]) - 33'(last_pos_reg[idx_reg]));
    assign dot_abs = mag33(33'(dot_reg));
    assign dmag = (dot_abs > 32'h1000_0000) ? 29'h1000_0000 : dot_abs[28:0];

    // single shared multiplier, operands chosen by state
    always_comb begin
        case (state_reg)
            S_QSQ_MUL: begin
                mul_a = qmag;
                mul_b = qmag;
            end
            S_PSQ_MUL: begin
                mul_a = pmag;
                mul_b = pmag;
            end
            S_DOT_MUL: begin
                mul_a = mag33(33'(n_reg[idx_reg]));
                mul_b = mag33(33'(last_ori_reg[idx_reg]));
            end
            S_DSQ_MUL: begin
                mul_a = {3'd0, dmag};
                mul_b = {3'd0, dmag};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        case (state_reg)
            S_CHECK:   sqrt_in = {3'd0, acc_reg[32:0], 28'd0};
            S_PSQ_CHK: sqrt_in = acc_reg[63:0];
            S_DSQ_SUB: sqrt_in = (64'd1 << 56) - prod_reg;
            default:   sqrt_in = '0;
        endcase
    end

    assign nmag = ({1'b0, div_quot} > {1'b0, Q_ONE_Q14}) ? {1'b0, Q_ONE_Q14}
                                                         : {1'b0, div_quot};
    assign ncap = nmag[15:0];

    assign fin_rst = (frame_reg < last_frame_reg) || (pstep_reg > {1'b0, max_pos_reg}) ||
                     (cordic_step > max_ori_reg);
    assign cnt_up  = (count_reg < req_frames_reg) ? count_reg + 16'd1 : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        sqrt_start   = 1'b0;
        div_start    = 1'b0;
        cordic_start = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) state_next = S_QSQ_MUL;
            end
            S_QSQ_MUL: state_next = S_QSQ_ACC;
            S_QSQ_ACC: begin
                state_next = (idx_reg == 2'd3) ? S_CHECK : S_QSQ_MUL;
            end
            S_CHECK: begin
                if (invalid) begin
                    state_next = S_OUT;
                end else begin
                    sqrt_start = 1'b1;
                    state_next = S_LEN;
                end
            end
            S_LEN: begin
                if (sqrt_done) state_next = S_DIV_GO;
            end
            S_DIV_GO: begin
                div_start  = 1'b1;
                state_next = S_NORM;
            end
            S_NORM: begin
                if (div_done) state_next = (idx_reg == 2'd3) ? S_DECIDE : S_DIV_GO;
            end
            S_DECIDE: begin
                if (!have_reg || frame_reg == last_frame_reg) state_next = S_OUT;
                else state_next = S_PSQ_MUL;
            end
            S_PSQ_MUL: state_next = S_PSQ_ACC;
            S_PSQ_ACC: begin
                state_next = (idx_reg == 2'd2) ? S_PSQ_CHK : S_PSQ_MUL;
            end
            S_PSQ_CHK: begin
                if (acc_reg[65:64] != 2'd0) begin
                    state_next = S_DOT_MUL;
                end else begin
                    sqrt_start = 1'b1;
                    state_next = S_PSQRT;
                end
            end
            S_PSQRT: begin
                if (sqrt_done) state_next = S_DOT_MUL;
            end
            S_DOT_MUL: state_next = S_DOT_ACC;
            S_DOT_ACC: begin
                state_next = (idx_reg == 2'd3) ? S_DSQ_MUL : S_DOT_MUL;
            end
            S_DSQ_MUL: state_next = S_DSQ_SUB;
            S_DSQ_SUB: begin
                sqrt_start = 1'b1;
                state_next = S_ACOS_SQRT;
            end
            S_ACOS_SQRT: begin
                if (sqrt_done) begin
                    cordic_start = 1'b1;
                    state_next   = S_CORDIC;
                end
            end
            S_CORDIC: begin
                if (cordic_done) state_next = S_FINISH;
            end
            S_FINISH: state_next = S_OUT;
            S_OUT: begin
                if (out_load) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // configuration and tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_frames_reg <= 16'd1;
            max_pos_reg    <= 31'd65536;
            max_ori_reg    <= 15'd8192;
            have_reg       <= 1'b0;
            count_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_REQUIRED_FRAMES:      req_frames_reg <= cfg_data[15:0];
                    CFG_MAX_POSITION_STEP:    max_pos_reg    <= cfg_data[30:0];
                    CFG_MAX_ORIENTATION_STEP: max_ori_reg    <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (state_reg == S_CHECK && invalid) begin
                have_reg  <= 1'b0;
                count_reg <= '0;
            end else if (state_reg == S_DECIDE && !have_reg) begin
                have_reg  <= 1'b1;
                count_reg <= 16'd1;
            end else if (state_reg == S_FINISH) begin
                count_reg <= fin_rst ? 16'd1 : cnt_up;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_DECIDE && !have_reg) || state_reg == S_FINISH) begin
            last_frame_reg <= frame_reg;
            for (int i = 0; i < 4; i++) last_ori_reg[i] <= n_reg[i];
            for (int i = 0; i < 3; i++) last_pos_reg[i] <= p_reg[i];
        end
    end

    // work registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    frame_reg <= s_frame_number;
                    q_reg[0]  <= s_quat_x;
                    q_reg[1]  <= s_quat_y;
                    q_reg[2]  <= s_quat_z;
                    q_reg[3]  <= s_quat_w;
                    p_reg[0]  <= s_pos_x;
                    p_reg[1]  <= s_pos_y;
                    p_reg[2]  <= s_pos_z;
                    acc_reg   <= '0;
                    idx_reg   <= '0;
                end
            end
            S_QSQ_ACC: begin
                acc_reg <= acc_reg + 66'(prod_reg);
                idx_reg <= idx_reg + 2'd1;
            end
            S_CHECK: begin
                res_status_reg <= STATUS_INVALID;
                res_pos_reg    <= '0;
                res_ori_reg    <= '0;
            end
            S_LEN: begin
                if (sqrt_done) begin
                    len_reg <= sqrt_root[30:0];
                    idx_reg <= '0;
                end
            end
            S_NORM: begin
                if (div_done) begin
                    n_reg[idx_reg] <= q_reg[idx_reg][15] ? -signed'(ncap) : signed'(ncap);
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            S_DECIDE: begin
                acc_reg <= '0;
                dot_reg <= '0;
                idx_reg <= '0;
                if (!have_reg) begin
                    res_status_reg <= (req_frames_reg == 16'd1) ? STATUS_READY
                                                                : STATUS_STARTED;
                end else begin
                    res_status_reg <= STATUS_DUPLICATE;
                end
            end
            S_PSQ_ACC: begin
                acc_reg <= acc_reg + 66'(prod_reg);
                idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
            end
            S_PSQ_CHK: begin
                pstep_reg <= 32'hFFFF_FFFF;
            end
            S_PSQRT: begin
                if (sqrt_done) pstep_reg <= sqrt_root;
            end
            S_DOT_ACC: begin
                if (n_reg[idx_reg][15] ^ last_ori_reg[idx_reg][15]) begin
                    dot_reg <= dot_reg - signed'(prod_reg[31:0]);
                end else begin
                    dot_reg <= dot_reg + signed'(prod_reg[31:0]);
                end
                idx_reg <= idx_reg + 2'd1;
            end
            S_DSQ_MUL: begin
                dmag_reg <= dmag;
            end
            S_FINISH: begin
                res_pos_reg    <= pstep_reg;
                res_ori_reg    <= cordic_step;
                if (fin_rst) begin
                    res_status_reg <= STATUS_RESET;
                end else begin
                    res_status_reg <= (cnt_up >= req_frames_reg) ? STATUS_READY
                                                                 : STATUS_ACCUMULATING;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_pos_reg    <= res_pos_reg;
            m_ori_reg    <= res_ori_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_position_step    = m_pos_reg;
    assign m_orientation_step = m_ori_reg;

    pst_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // numerator |q| * 2^28 plus half the length, for round half away from zero
    pst_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({qmag[15:0], 28'd0} + {14'd0, len_reg[30:1]}),
        .den     (len_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    pst_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .x0      (dmag_reg),
        .y0      (sqrt_root[28:0]),
        .done    (cordic_done),
        .step    (cordic_step)
    );

endmodule

@@ tb/pst_checker.sv @@
module pst_checker
    import pst_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [63:0]          s_frame_number,
    input  logic signed [15:0]   s_quat_x,
    input  logic signed [15:0]   s_quat_y,
    input  logic signed [15:0]   s_quat_z,
    input  logic signed [15:0]   s_quat_w,
    input  logic signed [31:0]   s_pos_x,
    input  logic signed [31:0]   s_pos_y,
    input  logic signed [31:0]   s_pos_z,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [2:0]           m_status,
    input  logic [31:0]          m_position_step,
    input  logic [14:0]          m_orientation_step,
    output int                   failures,
    output int                   pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] pos_step;
        logic [14:0] rot_step;
    } pose_result_t;

    // atan(2^-i), 2^-20 rad units
    localparam longint ATAN_LUT [0:20] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1
    };

    pose_result_t expected_results[$];

    logic [15:0] req_frames;
    logic [30:0] pos_limit;
    logic [14:0] rot_limit;

    logic         tracking;
    logic [63:0]  prev_frame;
    longint       prev_quat [4];
    longint       prev_pos [3];
    logic [15:0]  run_len;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // rotation angle from |dot| in Q28 via sqrt and cordic vectoring
    function automatic logic [14:0] rotation_angle(input longint d);
        longint x, y, z, nx;
        logic [63:0] r;
        y = longint'(int_sqrt((64'd1 << 56) - 64'(d * d)));
        x = d;
        z = 0;
        for (int i = 0; i < 21; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_LUT[i];
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_LUT[i];
            end
            x = nx;
        end
        if (z < 0) z = 0;
        r = (64'(z) + 64'd32) >> 6;
        return (r > 64'd25736) ? 15'd25736 : r[14:0];
    endfunction

    function automatic void clear_track();
        tracking = 0;
        prev_frame = 0;
        run_len = 0;
        foreach (prev_quat[i]) prev_quat[i] = 0;
        foreach (prev_pos[i]) prev_pos[i] = 0;
    endfunction

    function automatic pose_result_t track_pose(input logic [63:0] frame,
                                                input longint q [4],
                                                input longint p [3]);
        pose_result_t res;
        logic [63:0] sum_sq, len, a, m, sq;
        logic [65:0] psum;
        longint nq [4];
        longint dot, dd;
        logic [31:0] pstep;
        logic [14:0] ostep;
        res = '0;
        sum_sq = 0;
        foreach (q[i]) sum_sq = sum_sq + 64'(q[i] * q[i]);
        if (frame == 0 || sum_sq < 3 || req_frames == 0 || pos_limit == 0 ||
            rot_limit == 0) begin
            clear_track();
            res.status = STATUS_INVALID;
            return res;
        end
        len = int_sqrt(sum_sq << 28);
        foreach (q[i]) begin
            a = 64'(q[i] < 0 ? -q[i] : q[i]);
            m = ((a << 28) + (len >> 1)) / len;
            if (m > 16384) m = 16384;
            nq[i] = q[i] < 0 ? -longint'(m) : longint'(m);
        end
        if (!tracking) begin
            tracking = 1;
            prev_frame = frame;
            prev_quat = nq;
            prev_pos = p;
            run_len = 1;
            res.status = (req_frames == 1) ? STATUS_READY : STATUS_STARTED;
            return res;
        end
        if (frame == prev_frame) begin
            res.status = STATUS_DUPLICATE;
            return res;
        end
        psum = 0;
        foreach (p[i]) begin
            dd = p[i] - prev_pos[i];
            a = 64'(dd < 0 ? -dd : dd);
            sq = a * a;
            psum = psum + 66'(sq);
        end
        if (psum[65:64] != 2'd0) begin
            pstep = 32'hFFFF_FFFF;
        end else begin
            m = int_sqrt(psum[63:0]);
            pstep = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
        end
        dot = 0;
        foreach (nq[i]) dot = dot + nq[i] * prev_quat[i];
        if (dot < 0) dot = -dot;
        if (dot > (longint'(1) << 28)) dot = longint'(1) << 28;
        ostep = rotation_angle(dot);
        res.pos_step = pstep;
        res.rot_step = ostep;
        if (frame < prev_frame || pstep > {1'b0, pos_limit} || ostep > rot_limit) begin
            run_len = 1;
            res.status = STATUS_RESET;
        end else begin
            if (run_len < req_frames) run_len = run_len + 16'd1;
            res.status = (run_len >= req_frames) ? STATUS_READY : STATUS_ACCUMULATING;
        end
        prev_frame = frame;
        prev_quat = nq;
        prev_pos = p;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
        failures++;
    endtask

    initial begin
        failures = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        pose_result_t got, want;
        longint q [4];
        longint p [3];
        if (!aresetn) begin
            req_frames = 16'd1;
            pos_limit = 31'd65536;
            rot_limit = 15'd8192;
            clear_track();
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_REQUIRED_FRAMES:      req_frames = cfg_data[15:0];
                    CFG_MAX_POSITION_STEP:    pos_limit = cfg_data[30:0];
                    CFG_MAX_ORIENTATION_STEP: rot_limit = cfg_data[14:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                q = '{s_quat_x, s_quat_y, s_quat_z, s_quat_w};
                p = '{s_pos_x, s_pos_y, s_pos_z};
                expected_results.push_back(track_pose(s_frame_number, q, p));
            end
            // result transfer
            if (m_valid && m_ready) begin
                got = '{m_status, m_position_step, m_orientation_step};
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, status", got.status, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.pos_step !== want.pos_step)
                        report_mismatch("position_step", got.pos_step, want.pos_step);
                    if (got.rot_step !== want.rot_step)
                        report_mismatch("orientation_step", got.rot_step, want.rot_step);
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

@@ tb/tb.sv @@
module tb;
    import pst_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [63:0]          s_frame_number;
    logic signed [15:0]   s_quat_x, s_quat_y, s_quat_z, s_quat_w;
    logic signed [31:0]   s_pos_x, s_pos_y, s_pos_z;
    logic                 m_valid;
    logic                 m_ready;
    logic [2:0]           m_status;
    logic [31:0]          m_position_step;
    logic [14:0]          m_orientation_step;

    int failures;
    int pending;
    bit steady;

    pose_stability_tracker DUT (.*);

    pst_checker scoreboard (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        #20_000_000;
        $display("pose_stability_tracker regression: fail");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= steady || ($urandom_range(99) >= 35);
    end

    task automatic send_pose(input logic [63:0] frame,
                             input logic [15:0] qx, qy, qz, qw,
                             input logic [31:0] px, py, pz);
        int gap;
        gap = (!steady && $urandom_range(99) < 35) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_frame_number <= frame;
        s_quat_x <= qx;
        s_quat_y <= qy;
        s_quat_z <= qz;
        s_quat_w <= qw;
        s_pos_x <= px;
        s_pos_y <= py;
        s_pos_z <= pz;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold off until every result is back and the block is quiet
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(input logic [31:0] frames, pos, rot);
        write_reg(CFG_REQUIRED_FRAMES, frames);
        write_reg(CFG_MAX_POSITION_STEP, pos);
        write_reg(CFG_MAX_ORIENTATION_STEP, rot);
    endtask

    // mostly a steadily moving pose, with duplicates, rewinds, jumps and noise
    task automatic track_walk(input int count);
        logic [63:0] frame;
        logic [15:0] q [4];
        logic [31:0] p [3];
        logic [15:0] nq [4];
        logic [31:0] np [3];
        int pick;
        frame = {$urandom, $urandom} >> $urandom_range(0, 63);
        foreach (q[i]) q[i] = 16'($urandom);
        foreach (p[i]) p[i] = $urandom_range(0, 200000) - 100000;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                // noise sample
                foreach (nq[i]) nq[i] = 16'($urandom);
                foreach (np[i]) np[i] = $urandom;
                send_pose({$urandom, $urandom}, nq[0], nq[1], nq[2], nq[3],
                          np[0], np[1], np[2]);
                continue;
            end
            if (pick < 80) frame = frame + 1;
            else if (pick < 85) ;
            else if (pick < 90) frame = frame - $urandom_range(1, 5);
            else if (pick < 92) frame = 0;
            else if (pick < 95) frame = {$urandom, $urandom};
            else begin
                frame = frame + 1;
                foreach (q[i]) q[i] = 16'($urandom);
            end
            foreach (q[i]) q[i] = 16'(q[i] + $urandom_range(0, 400) - 200);
            foreach (p[i]) p[i] = p[i] + $urandom_range(0, 80000) - 40000;
            if ($urandom_range(99) < 3) p[$urandom_range(2)] = $urandom;
            send_pose(frame, q[0], q[1], q[2], q[3], p[0], p[1], p[2]);
            if (frame == 0) frame = 64'($urandom);
        end
    endtask

    initial begin
        steady = 1'b0;
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_frame_number <= '0;
        s_quat_x <= '0;
        s_quat_y <= '0;
        s_quat_z <= '0;
        s_quat_w <= '0;
        s_pos_x <= '0;
        s_pos_y <= '0;
        s_pos_z <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset settings
        send_pose(64'd0, 0, 0, 0, 16384, 0, 0, 0);
        send_pose(64'd3, 1, 1, 0, 0, 0, 0, 0);
        send_pose(64'd3, 1, 1, 1, 0, 0, 0, 0);
        send_pose(64'd0, 0, 0, 0, 16384, 0, 0, 0);
        send_pose(64'd10, 0, 0, 0, 16384, 0, 0, 0);
        send_pose(64'd10, 0, 0, 0, 16384, 5, 5, 5);
        send_pose(64'd11, 0, 0, 0, 16384, 0, 0, 0);
        send_pose(64'd12, 0, 0, 0, 16384, 32'd65536, 0, 0);
        send_pose(64'd13, 0, 0, 0, 16384, 32'd131073, 0, 0);
        send_pose(64'd5, 0, 0, 0, 16384, 32'd131073, 0, 0);
        send_pose(64'd6, 11585, 0, 0, 11585, 32'd131073, 0, 0);
        send_pose(64'd7, -11585, 0, 0, -11585, 32'd131073, 0, 0);
        send_pose(64'd8, -32768, -32768, -32768, -32768, 0, 0, 0);
        send_pose(64'd9, 32767, 32767, 32767, 32767, 0, 0, 0);
        send_pose(64'd10, 0, 0, 0, -32768, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pose(64'd11, 0, 0, 0, -32768, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_pose(64'hFFFF_FFFF_FFFF_FFFF, 0, 32767, 0, 0, 32'h8000_0000, 0, 0);
        send_pose(64'd1, 0, 0, -32768, 0, 0, 0, 0);
        send_pose(64'd2, 16384, 0, 0, 0, 0, 0, 0);
        track_walk(150);
        drain();

        set_limits(3, 100000, 4000);
        track_walk(300);
        drain();

        set_limits(0, 65536, 8192);
        track_walk(30);
        drain();

        steady = 1'b1;
        set_limits(65535, 32'hFFFF_FFFF, 25736);
        track_walk(250);
        drain();
        steady = 1'b0;

        set_limits(1, 1, 1);
        track_walk(200);
        drain();

        set_limits(2, 0, 8192);
        track_walk(25);
        drain();
        set_limits(2, 65536, 0);
        track_walk(25);
        drain();

        set_limits(5, 200000, 3000);
        write_reg(8'd3, 32'hFFFF_FFFF);
        write_reg(8'hFF, 32'd0);
        track_walk(400);
        drain();

        set_limits(32'hFFFF_0002, 32'h8001_0000, 32'hFFFF_9000);
        track_walk(120);
        drain();

        if (failures == 0)
            $display("pose_stability_tracker regression: pass");
        else
            $display("pose_stability_tracker regression: fail");
        $finish;
    end

endmodule
